[hdl/ssi_pkg.sv]
// ----------------------------------------------------------------------------
// ssi_pkg: shared types and constants for the segment/sphere test
// Holds the limb width used by the wide multipliers and the flag bundle
// that travels from the condition stage to the output stage.
// ----------------------------------------------------------------------------
package ssi_pkg;

    // Limb width for the split multipliers (limb products stay <= 17x17)
    localparam int LIMB_W = 17;

    // Root-range conditions formed before the discriminant sign is known
    typedef struct packed {
        logic zero_a;      // zero-length segment
        logic enters_pre;  // t1 in [0,1] provided the discriminant is >= 0
        logic leaves_pre;  // t2 in [0,1] provided the discriminant is >= 0
    } cond_t;

endpackage

[hdl/ssi_prep.sv]
// ----------------------------------------------------------------------------
// ssi_prep: difference vectors and dot products
// Three stages: d = E - S and f = S - C; the ten lane products;
// the sums a = d.d, h = f.d and c = f.f - r*r.
// ----------------------------------------------------------------------------
module ssi_prep #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid_in,
    input  logic signed [COORD_WIDTH-1:0]  s_pt [3],
    input  logic signed [COORD_WIDTH-1:0]  e_pt [3],
    input  logic signed [COORD_WIDTH-1:0]  c_pt [3],
    input  logic        [COORD_WIDTH-1:0]  rad,
    output logic                           valid_out,
    output logic signed [2*COORD_WIDTH+2:0] a_out,
    output logic signed [2*COORD_WIDTH+2:0] h_out,
    output logic signed [2*COORD_WIDTH+2:0] c_out
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;       // difference width
    localparam int MW  = 2 * W + 2;   // lane product width
    localparam int SW  = 2 * W + 3;   // dot product width

    logic [2:0] vld_reg;

    // stage 1: differences
    logic signed [DW-1:0] d_reg [3], d_next [3];
    logic signed [DW-1:0] f_reg [3], f_next [3];
    logic        [W-1:0]  r_reg;

    // stage 2: lane products
    logic signed [MW-1:0] dd_reg [3], dd_next [3];
    logic signed [MW-1:0] fd_reg [3], fd_next [3];
    logic signed [MW-1:0] ff_reg [3], ff_next [3];
    logic        [2*W-1:0] rr_reg, rr_next;

    // stage 3: sums
    logic signed [SW-1:0] a_reg, a_next;
    logic signed [SW-1:0] h_reg, h_next;
    logic signed [SW-1:0] c_reg, c_next;

    // differences, sign extended by one bit
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_next[k] = DW'(e_pt[k]) - DW'(s_pt[k]);
            f_next[k] = DW'(s_pt[k]) - DW'(c_pt[k]);
        end
    end

    // per-lane products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dd_next[k] = MW'(d_reg[k]) * MW'(d_reg[k]);
            fd_next[k] = MW'(f_reg[k]) * MW'(d_reg[k]);
            ff_next[k] = MW'(f_reg[k]) * MW'(f_reg[k]);
        end
        rr_next = (2*W)'(r_reg) * (2*W)'(r_reg);
    end

    // three-lane sums
    always_comb
    begin
        a_next = SW'(dd_reg[0]) + SW'(dd_reg[1]) + SW'(dd_reg[2]);
        h_next = SW'(fd_reg[0]) + SW'(fd_reg[1]) + SW'(fd_reg[2]);
        c_next = SW'(ff_reg[0]) + SW'(ff_reg[1]) + SW'(ff_reg[2])
               - SW'($signed({1'b0, rr_reg}));
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], valid_in};
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        d_reg  <= d_next;
        f_reg  <= f_next;
        r_reg  <= rad;
        dd_reg <= dd_next;
        fd_reg <= fd_next;
        ff_reg <= ff_next;
        rr_reg <= rr_next;
        a_reg  <= a_next;
        h_reg  <= h_next;
        c_reg  <= c_next;
    end

    assign valid_out = vld_reg[2];
    assign a_out     = a_reg;
    assign h_out     = h_reg;
    assign c_out     = c_reg;

endmodule

[hdl/ssi_cond.sv]
// ----------------------------------------------------------------------------
// ssi_cond: root range conditions
// One stage: forms h+a and 2h+a+c, evaluates the sign tests for both
// roots, and prepares unsigned magnitudes for the discriminant products.
// ----------------------------------------------------------------------------
module ssi_cond #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            valid_in,
    input  logic signed [2*COORD_WIDTH+2:0] a_in,
    input  logic signed [2*COORD_WIDTH+2:0] h_in,
    input  logic signed [2*COORD_WIDTH+2:0] c_in,
    output logic                            valid_out,
    output ssi_pkg::cond_t                  cond,
    output logic        [2*COORD_WIDTH+1:0] h_mag,
    output logic        [2*COORD_WIDTH+1:0] a_mag,
    output logic        [2*COORD_WIDTH+1:0] c_pos
);

    localparam int SW = 2 * COORD_WIDTH + 3;
    localparam int EW = SW + 2;
    localparam int UW = SW - 1;

    logic                 vld_reg;
    ssi_pkg::cond_t       cond_reg, cond_next;
    logic [UW-1:0]        hm_reg, hm_next;
    logic [UW-1:0]        am_reg;
    logic [UW-1:0]        cp_reg, cp_next;

    logic signed [EW-1:0] ha;
    logic signed [EW-1:0] e;
    logic signed [SW-1:0] h_neg;
    logic                 h_le0, c_ge0, c_le0, ha_ge0, e_le0, e_ge0;

    // sign tests on h, c, h+a and 2h+a+c
    always_comb
    begin
        ha     = EW'(h_in) + EW'(a_in);
        e      = EW'(h_in) + EW'(h_in) + EW'(a_in) + EW'(c_in);
        h_le0  = h_in[SW-1] || (h_in == '0);
        c_ge0  = !c_in[SW-1];
        c_le0  = c_in[SW-1] || (c_in == '0);
        ha_ge0 = !ha[EW-1];
        e_le0  = e[EW-1] || (e == '0);
        e_ge0  = !e[EW-1];

        cond_next.zero_a     = (a_in == '0);
        cond_next.enters_pre = h_le0 && c_ge0 && (ha_ge0 || e_le0);
        cond_next.leaves_pre = (h_le0 || c_le0) && ha_ge0 && e_ge0;
    end

    // magnitudes; a negative c makes a*c <= h*h, so it counts as zero
    always_comb
    begin
        h_neg   = -h_in;
        hm_next = h_in[SW-1] ? h_neg[UW-1:0] : h_in[UW-1:0];
        cp_next = c_in[SW-1] ? '0 : c_in[UW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        cond_reg <= cond_next;
        hm_reg   <= hm_next;
        am_reg   <= a_in[UW-1:0];
        cp_reg   <= cp_next;
    end

    assign valid_out = vld_reg;
    assign cond      = cond_reg;
    assign h_mag     = hm_reg;
    assign a_mag     = am_reg;
    assign c_pos     = cp_reg;

endmodule

[hdl/ssi_wmul.sv]
// ----------------------------------------------------------------------------
// ssi_wmul: pipelined wide unsigned multiplier
// Splits both operands into limbs. Stage 1 forms the limb products,
// stage 2 sums each row, stage 3 sums the rows.
// ----------------------------------------------------------------------------
module ssi_wmul #(
    parameter int OP_W = 34
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  logic [OP_W-1:0]   op_a,
    input  logic [OP_W-1:0]   op_b,
    output logic              valid_out,
    output logic [2*OP_W-1:0] prod
);

    localparam int LW     = ssi_pkg::LIMB_W;
    localparam int NL     = (OP_W + LW - 1) / LW;
    localparam int PAD_W  = NL * LW;
    localparam int ROW_W  = PAD_W + LW;
    localparam int PROD_W = 2 * PAD_W;

    logic [PAD_W-1:0]  a_pad, b_pad;
    logic [2:0]        vld_reg;
    logic [2*LW-1:0]   pp_reg  [NL][NL];
    logic [2*LW-1:0]   pp_next [NL][NL];
    logic [ROW_W-1:0]  row_reg  [NL];
    logic [ROW_W-1:0]  row_next [NL];
    logic [PROD_W-1:0] sum_reg, sum_next;

    assign a_pad = PAD_W'(op_a);
    assign b_pad = PAD_W'(op_b);

    // limb products
    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            for (int j = 0; j < NL; j++)
            begin
                pp_next[i][j] = (2*LW)'(a_pad[i*LW +: LW]) * (2*LW)'(b_pad[j*LW +: LW]);
            end
        end
    end

    // row sums: limb i of op_a times all of op_b
    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NL; j++)
            begin
                row_next[i] = row_next[i] + (ROW_W'(pp_reg[i][j]) << (j * LW));
            end
        end
    end

    // final sum of shifted rows
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NL; i++)
        begin
            sum_next = sum_next + (PROD_W'(row_reg[i]) << (i * LW));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg  <= pp_next;
        row_reg <= row_next;
        sum_reg <= sum_next;
    end

    assign valid_out = vld_reg[2];
    assign prod      = sum_reg[2*OP_W-1:0];

    // every operand pair comes out as a valid product
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_in |-> ##3 valid_out)
        else $error("ssi_wmul: product transfer lost");

endmodule

[hdl/segment_sphere_intersect.sv]
// ----------------------------------------------------------------------------
// segment_sphere_intersect: segment versus sphere intersection flags
// Exact integer test of one segment against one sphere per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the nine coordinates and radius and raise start for one
//   cycle; the transfer is taken at that clock edge. busy is always low,
//   so a new segment may be offered in every cycle.
//   Output: done pulses for one cycle with enters, leaves and missed valid
//   in that cycle. Flags read zero while done is low.
//   Pipeline: three dot-product stages, one condition stage, three limb-split
//   discriminant multiplier stages, one output reg.
//   Throughput: one transfer per cycle; the multipliers are fully pipelined.
//   Ordering: results leave in the order segments entered.
//   Reset: rst_n clears every valid bit; items in flight are dropped.
//   The receiver has no back-pressure and must take each result as it
//   appears.
//   A zero-length segment reports no flags; missed excludes enters/leaves.
// ----------------------------------------------------------------------------
module segment_sphere_intersect #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] start_z,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    input  logic signed [COORD_WIDTH-1:0] end_z,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic        [COORD_WIDTH-1:0] radius,
    output logic                          done,
    output logic                          enters,
    output logic                          leaves,
    output logic                          missed
);

    localparam int SW = 2 * COORD_WIDTH + 3;
    localparam int UW = SW - 1;
    localparam int MUL_LAT = 3;

    logic signed [COORD_WIDTH-1:0] s_pt [3];
    logic signed [COORD_WIDTH-1:0] e_pt [3];
    logic signed [COORD_WIDTH-1:0] c_pt [3];

    logic                 prep_vld;
    logic signed [SW-1:0] a_val, h_val, c_val;

    logic                 cond_vld;
    ssi_pkg::cond_t       cond;
    logic [UW-1:0]        h_mag, a_mag, c_pos;

    logic                 hh_vld, ac_vld;
    logic [2*UW-1:0]      hh, ac;

    ssi_pkg::cond_t       cond_dly_reg [MUL_LAT];
    logic                 q_neg;
    logic                 mul_vld;

    logic                 done_reg, done_next;
    logic                 enters_reg, enters_next;
    logic                 leaves_reg, leaves_next;
    logic                 missed_reg, missed_next;

    assign busy = 1'b0;

    assign s_pt = '{start_x, start_y, start_z};
    assign e_pt = '{end_x, end_y, end_z};
    assign c_pt = '{center_x, center_y, center_z};

    // dot products a, h, c
    ssi_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start && !busy),
        .s_pt      (s_pt),
        .e_pt      (e_pt),
        .c_pt      (c_pt),
        .rad       (radius),
        .valid_out (prep_vld),
        .a_out     (a_val),
        .h_out     (h_val),
        .c_out     (c_val)
    );

    // root range conditions and magnitudes
    ssi_cond #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cond (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (prep_vld),
        .a_in      (a_val),
        .h_in      (h_val),
        .c_in      (c_val),
        .valid_out (cond_vld),
        .cond      (cond),
        .h_mag     (h_mag),
        .a_mag     (a_mag),
        .c_pos     (c_pos)
    );

    // h*h and a*c for the quarter discriminant
    ssi_wmul #(
        .OP_W (UW)
    ) u_mul_hh (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (cond_vld),
        .op_a      (h_mag),
        .op_b      (h_mag),
        .valid_out (hh_vld),
        .prod      (hh)
    );

    ssi_wmul #(
        .OP_W (UW)
    ) u_mul_ac (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (cond_vld),
        .op_a      (a_mag),
        .op_b      (c_pos),
        .valid_out (ac_vld),
        .prod      (ac)
    );

    // conditions ride alongside the multipliers
    always_ff @(posedge clk)
    begin
        cond_dly_reg[0] <= cond;
        for (int i = 1; i < MUL_LAT; i++)
        begin
            cond_dly_reg[i] <= cond_dly_reg[i-1];
        end
    end

    // final flags: negative discriminant means a miss
    always_comb
    begin
        mul_vld     = hh_vld && ac_vld;
        q_neg       = (hh < ac);
        done_next   = mul_vld;
        missed_next = mul_vld && !cond_dly_reg[MUL_LAT-1].zero_a && q_neg;
        enters_next = mul_vld && !cond_dly_reg[MUL_LAT-1].zero_a && !q_neg
                      && cond_dly_reg[MUL_LAT-1].enters_pre;
        leaves_next = mul_vld && !cond_dly_reg[MUL_LAT-1].zero_a && !q_neg
                      && cond_dly_reg[MUL_LAT-1].leaves_pre;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            enters_reg <= 1'b0;
            leaves_reg <= 1'b0;
            missed_reg <= 1'b0;
        end
        else
        begin
            done_reg   <= done_next;
            enters_reg <= enters_next;
            leaves_reg <= leaves_next;
            missed_reg <= missed_next;
        end
    end

    assign done   = done_reg;
    assign enters = enters_reg;
    assign leaves = leaves_reg;
    assign missed = missed_reg;

    // each accepted transfer yields one result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##8 done)
        else $error("segment_sphere_intersect: result transfer lost");

    // a miss never comes with an entry or exit
    assert property (@(posedge clk) disable iff (!rst_n)
        missed |-> (!enters && !leaves))
        else $error("segment_sphere_intersect: miss with root flags");

    // flags only appear with the strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!enters && !leaves && !missed))
        else $error("segment_sphere_intersect: flags without done");

    // the two multiplier pipelines stay in step
    assert property (@(posedge clk) disable iff (!rst_n)
        hh_vld == ac_vld)
        else $error("segment_sphere_intersect: multiplier valid mismatch");

endmodule

[dv/segment_sphere_intersect_tb.sv]
// ----------------------------------------------------------------------------
// segment_sphere_intersect_tb: self-checking bench for the segment/sphere test
// Drives segments and spheres through the command port with random start
// gaps, predicts the enters/leaves/missed flags with exact 128-bit integer
// math, and checks each done pulse against the oldest prediction.
// ----------------------------------------------------------------------------
module segment_sphere_intersect_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW         = 16;
    localparam int RAND_ITEMS = 1000;
    localparam int STALL_MAX  = 1000;
    localparam int DRAIN_CYC  = 16;

    // One query: segment endpoints, sphere center and radius
    typedef struct packed {
        logic [CW-1:0] sx, sy, sz;
        logic [CW-1:0] ex, ey, ez;
        logic [CW-1:0] cx, cy, cz;
        logic [CW-1:0] rad;
    } segment_t;

    typedef struct packed {
        logic enters;
        logic leaves;
        logic missed;
    } flags_t;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    segment_t seg_in  = '0;
    logic     took    = 1'b0;
    wire      busy;
    wire      done;
    wire      enters;
    wire      leaves;
    wire      missed;

    segment_t pending_items[$];
    flags_t   expected_flags[$];
    int       drive_count    = 0;
    int       accepted_count = 0;
    int       total_items    = 0;
    int       stall_cycles   = 0;
    int       errors         = 0;

    segment_sphere_intersect #(
        .COORD_WIDTH(CW)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .start_x (seg_in.sx),
        .start_y (seg_in.sy),
        .start_z (seg_in.sz),
        .end_x   (seg_in.ex),
        .end_y   (seg_in.ey),
        .end_z   (seg_in.ez),
        .center_x(seg_in.cx),
        .center_y(seg_in.cy),
        .center_z(seg_in.cz),
        .radius  (seg_in.rad),
        .done    (done),
        .enters  (enters),
        .leaves  (leaves),
        .missed  (missed)
    );

    always #2 clk = ~clk;

    // Exact intersection flags; root range tests done by sign checks
    function automatic flags_t hit_flags(segment_t s);
        logic signed [127:0] d0, d1, d2, f0, f1, f2;
        logic signed [127:0] a, h, c, q, ha, e, r;
        flags_t fl;
        fl = '0;
        d0 = $signed(s.ex) - $signed(s.sx);
        d1 = $signed(s.ey) - $signed(s.sy);
        d2 = $signed(s.ez) - $signed(s.sz);
        f0 = $signed(s.sx) - $signed(s.cx);
        f1 = $signed(s.sy) - $signed(s.cy);
        f2 = $signed(s.sz) - $signed(s.cz);
        r  = $signed({112'd0, s.rad});
        a  = d0 * d0 + d1 * d1 + d2 * d2;
        h  = f0 * d0 + f1 * d1 + f2 * d2;
        c  = f0 * f0 + f1 * f1 + f2 * f2 - r * r;
        if (a != 0)
        begin
            q = h * h - a * c;
            if (q < 0)
            begin
                fl.missed = 1'b1;
            end
            else
            begin
                ha = h + a;
                e  = h + h + a + c;
                fl.enters = (h <= 0) && (c >= 0) && ((ha >= 0) || (e <= 0));
                fl.leaves = ((h <= 0) || (c <= 0)) && (ha >= 0) && (e >= 0);
            end
        end
        return fl;
    endfunction

    function automatic logic [CW-1:0] clamp_coord(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return 16'h8000;
        return v[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] jitter(int base, int span);
        return clamp_coord(base + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic segment_t make_seg(int sx, int sy, int sz, int ex, int ey,
                                          int ez, int cx, int cy, int cz, int r);
        segment_t s;
        s.sx  = clamp_coord(sx);
        s.sy  = clamp_coord(sy);
        s.sz  = clamp_coord(sz);
        s.ex  = clamp_coord(ex);
        s.ey  = clamp_coord(ey);
        s.ez  = clamp_coord(ez);
        s.cx  = clamp_coord(cx);
        s.cy  = clamp_coord(cy);
        s.cz  = clamp_coord(cz);
        s.rad = r[CW-1:0];
        return s;
    endfunction

    // Random query: mostly segments placed around the sphere, some noise
    function automatic segment_t random_seg();
        segment_t s;
        int pick, scale, cx, cy, cz, r, k;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       scale = $urandom_range(1, 64);
            1, 2:    scale = $urandom_range(1, 2000);
            default: scale = $urandom_range(1, 30000);
        endcase
        cx = $signed(16'($urandom));
        cy = $signed(16'($urandom));
        cz = $signed(16'($urandom));
        r  = $urandom_range(0, scale);
        if (pick < 20)
        begin
            s = segment_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        end
        else if (pick < 30)
        begin
            // zero-length segment somewhere near the sphere
            s = make_seg(0, 0, 0, 0, 0, 0, cx, cy, cz, r);
            s.sx = jitter(cx, 2 * scale);
            s.sy = jitter(cy, 2 * scale);
            s.sz = jitter(cz, 2 * scale);
            s.ex = s.sx;
            s.ey = s.sy;
            s.ez = s.sz;
        end
        else if (pick < 38)
        begin
            // line grazing the sphere along x, one unit either side or exactly touching
            k = $urandom_range(0, 2) - 1;
            s = make_seg(cx - int'($urandom_range(0, 2 * scale)), cy + r + k, cz,
                         cx + int'($urandom_range(0, 2 * scale)) - scale, cy + r + k,
                         cz, cx, cy, cz, r);
        end
        else
        begin
            s = make_seg(0, 0, 0, 0, 0, 0, cx, cy, cz, r);
            s.sx = jitter(cx, 2 * scale);
            s.sy = jitter(cy, 2 * scale);
            s.sz = jitter(cz, 2 * scale);
            s.ex = jitter(cx, 2 * scale);
            s.ey = jitter(cy, 2 * scale);
            s.ez = jitter(cz, 2 * scale);
        end
        return s;
    endfunction

    // Driver: present the next query at the falling edge once the last one is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || took)
            begin
                if (pending_items.size() != 0 &&
                    ($urandom_range(0, 99) >= 25 ||
                     (drive_count >= 400 && drive_count < 650)))
                begin
                    seg_in      <= pending_items.pop_front();
                    start       <= 1'b1;
                    drive_count <= drive_count + 1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: record transfers in, check results out
    always @(posedge clk)
    begin
        flags_t want;
        if (rst_n)
        begin
            took <= start && !busy;
            if (start && !busy)
            begin
                expected_flags.push_back(hit_flags(seg_in));
                accepted_count <= accepted_count + 1;
            end
            if (done)
            begin
                if (expected_flags.size() == 0)
                begin
                    $error("result with no query pending");
                    errors++;
                end
                else
                begin
                    want = expected_flags.pop_front();
                    if (enters !== want.enters)
                    begin
                        $error("enters: expected %0b, actual %0b", want.enters, enters);
                        errors++;
                    end
                    if (leaves !== want.leaves)
                    begin
                        $error("leaves: expected %0b, actual %0b", want.leaves, leaves);
                        errors++;
                    end
                    if (missed !== want.missed)
                    begin
                        $error("missed: expected %0b, actual %0b", want.missed, missed);
                        errors++;
                    end
                end
            end
            stall_cycles <= ((start && !busy) || done) ? 0 : stall_cycles + 1;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (stall_cycles >= STALL_MAX)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus and end of test
    initial
    begin
        // zero-length segments
        pending_items.push_back(make_seg(-32768, -32768, -32768, -32768, -32768, -32768,
                                         -32768, -32768, -32768, 0));
        pending_items.push_back(make_seg(3, 4, 5, 3, 4, 5, 0, 0, 0, 100));
        pending_items.push_back(make_seg(32767, 32767, 32767, 32767, 32767, 32767,
                                         -32768, -32768, -32768, 65535));
        // full-range extremes
        pending_items.push_back(make_seg(-32768, -32768, -32768, 32767, 32767, 32767,
                                         0, 0, 0, 65535));
        pending_items.push_back(make_seg(32767, 32767, 32767, -32768, -32768, -32768,
                                         -32768, -32768, -32768, 65535));
        pending_items.push_back(make_seg(-32768, 32767, -32768, 32767, -32768, 32767,
                                         32767, 32767, 32767, 0));
        pending_items.push_back(make_seg(32767, -32768, 32767, -32768, 32767, -32768,
                                         -32768, 32767, -32768, 1));
        // tangent: double root inside and outside the segment
        pending_items.push_back(make_seg(-10, 5, 0, 10, 5, 0, 0, 0, 0, 5));
        pending_items.push_back(make_seg(10, 5, 0, 20, 5, 0, 0, 0, 0, 5));
        pending_items.push_back(make_seg(-5, 0, 0, 5, 0, 0, 0, 0, 0, 0));
        // line misses the sphere
        pending_items.push_back(make_seg(-10, 20, 0, 10, 20, 0, 0, 0, 0, 5));
        pending_items.push_back(make_seg(-10, 6, 0, 10, 6, 0, 0, 0, 0, 5));
        // through, starts inside, ends inside, fully inside, sphere behind/ahead
        pending_items.push_back(make_seg(-10, 0, 0, 10, 0, 0, 0, 0, 0, 5));
        pending_items.push_back(make_seg(0, 0, 0, 10, 0, 0, 0, 0, 0, 5));
        pending_items.push_back(make_seg(-10, 0, 0, 0, 0, 0, 0, 0, 0, 5));
        pending_items.push_back(make_seg(-1, 0, 0, 1, 0, 0, 0, 0, 0, 5));
        pending_items.push_back(make_seg(10, 0, 0, 20, 0, 0, 0, 0, 0, 5));
        pending_items.push_back(make_seg(-20, 0, 0, -10, 0, 0, 0, 0, 0, 5));
        // endpoints exactly on the surface
        pending_items.push_back(make_seg(-5, 0, 0, 5, 0, 0, 0, 0, 0, 5));
        pending_items.push_back(make_seg(0, -3, -4, 0, 3, 4, 0, 0, 0, 5));
        pending_items.push_back(make_seg(-3, -4, 0, 3, 4, 0, 0, 0, 0, 5));
        for (int i = 0; i < RAND_ITEMS; i++)
            pending_items.push_back(random_seg());
        total_items = pending_items.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_items)
            @(negedge clk);
        while (expected_flags.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
